### rtl/torq_pkg.sv
// Shared types and constants for the timestamp-ordered request table.
// Used by torq_cell and timestamp_ordered_request_table; no dependencies.
package torq_pkg;

  // Operation codes carried in req_type
  localparam logic [1:0] OP_ADD     = 2'd0;
  localparam logic [1:0] OP_QUERY   = 2'd1;
  localparam logic [1:0] OP_DROP    = 2'd2;
  localparam logic [1:0] OP_RELEASE = 2'd3;

  localparam int unsigned ID_W    = 8;
  localparam int unsigned STAMP_W = 48;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned POS_W   = 4;

  // Incoming request
  typedef struct packed {
    logic [1:0]         req_type;
    logic [ID_W-1:0]    requester_id;
    logic [STAMP_W-1:0] time_stamp;
    logic [CNT_W-1:0]   count;
  } req_t;

  // Result of one request
  typedef struct packed {
    logic             present;
    logic [POS_W-1:0] position;
    logic             granted;
    logic [CNT_W-1:0] removed;
    logic [CNT_W-1:0] occupancy;
    logic             overflow;
  } rsp_t;

  // Per-cycle command to every cell of the chain
  typedef struct packed {
    logic cap;     // latch compare flags against the incoming request
    logic add_go;  // open a gap and insert the held request
    logic shl;     // move every entry one place toward the head
  } cell_ctl_t;

endpackage

### rtl/timestamp_ordered_request_table.sv
// Sorted request table on a chain of cells; depends on torq_pkg, torq_cell and torq_enc.
// Add, query, and drop or release that removes nothing: decoded in S_DEC, then the result
// is registered; a new request is taken only once the table is back in S_IDLE.
// Drop or release of n > 0 entries: one shift per cycle in S_SHIFT, then the result is
// registered and the table returns to S_IDLE. A held result delays the next one.
// Sync reset clears occupancy and control; table contents stay undefined, no clear pass.
module timestamp_ordered_request_table #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  torq_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output torq_pkg::rsp_t out_data
);

  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IW = $clog2(TABLE_DEPTH);
  localparam int unsigned GW = (IW > torq_pkg::CNT_W) ? IW : torq_pkg::CNT_W;
  localparam int unsigned MW = (CW > torq_pkg::CNT_W) ? CW : torq_pkg::CNT_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_DEC   = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;

  logic [1:0]           state;
  logic [CW-1:0]        occ;
  logic [CW-1:0]        sh_cnt;
  torq_pkg::req_t       req;
  torq_pkg::rsp_t       res;
  torq_pkg::cell_ctl_t  ctl;

  logic [TABLE_DEPTH-1:0] occ_vec;
  logic [TABLE_DEPTH-1:0] match_q;
  logic [TABLE_DEPTH-1:0] before_q;
  logic [TABLE_DEPTH-1:0] ins;
  logic [TABLE_DEPTH-1:0] left_before;
  logic [torq_pkg::ID_W-1:0]    cell_id    [TABLE_DEPTH];
  logic [torq_pkg::STAMP_W-1:0] cell_stamp [TABLE_DEPTH];

  logic [IW-1:0]  rank;
  logic [IW-1:0]  slot;
  logic           hit;
  logic           full;
  logic           accept;
  logic           out_free;
  logic           out_load;
  logic [MW-1:0]  drop_n;
  logic [CW-1:0]  n_rm;
  logic [CW-1:0]  occ_new;
  logic           do_add;
  torq_pkg::rsp_t res_new;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  // Result register loads when the work is done and the output slot is free
  assign out_load = out_free && (((state == S_DEC) && (n_rm == '0)) ||
                                 ((state == S_SHIFT) && (sh_cnt == '0)));

  // Cell chain
  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    assign occ_vec[k] = (CW'(k) < occ);

    if (k == 0) begin : g_head
      assign left_before[k] = 1'b0;
      assign ins[k]         = before_q[k];
    end else begin : g_body
      assign left_before[k] = before_q[k-1];
      assign ins[k]         = before_q[k] && !before_q[k-1];
    end

    torq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occupied    (occ_vec[k]),
      .cmp_id      (in_data.requester_id),
      .cmp_stamp   (in_data.time_stamp),
      .new_id      (req.requester_id),
      .new_stamp   (req.time_stamp),
      .left_before (left_before[k]),
      .left_id     (cell_id[(k == 0) ? 0 : k-1]),
      .left_stamp  (cell_stamp[(k == 0) ? 0 : k-1]),
      .right_id    (cell_id[(k == TABLE_DEPTH-1) ? k : k+1]),
      .right_stamp (cell_stamp[(k == TABLE_DEPTH-1) ? k : k+1]),
      .id          (cell_id[k]),
      .stamp       (cell_stamp[k]),
      .match       (match_q[k]),
      .new_first   (before_q[k])
    );
  end

  torq_enc #(.N(TABLE_DEPTH), .W(IW)) u_rank_enc (.onehot(match_q), .index(rank));
  torq_enc #(.N(TABLE_DEPTH), .W(IW)) u_slot_enc (.onehot(ins),     .index(slot));

  assign hit  = |match_q;
  assign full = (occ == CW'(TABLE_DEPTH));
  assign drop_n = (MW'(req.count) < MW'(occ)) ? MW'(req.count) : MW'(occ);

  // Decode the request once the compare flags are in
  always_comb begin
    res_new  = '0;
    n_rm     = '0;
    do_add   = 1'b0;
    case (req.req_type)
      torq_pkg::OP_ADD: begin
        if (hit) begin
          res_new.present  = 1'b1;
          res_new.position = torq_pkg::POS_W'(rank);
        end else if (full) begin
          res_new.overflow = 1'b1;
        end else begin
          do_add           = 1'b1;
          res_new.present  = 1'b1;
          res_new.position = torq_pkg::POS_W'(slot);
        end
      end
      torq_pkg::OP_QUERY: begin
        if (hit) begin
          res_new.present  = 1'b1;
          res_new.position = torq_pkg::POS_W'(rank);
          res_new.granted  = (GW'(rank) < GW'(req.count));
        end
      end
      torq_pkg::OP_DROP: begin
        n_rm = CW'(drop_n);
      end
      torq_pkg::OP_RELEASE: begin
        if (hit) begin
          res_new.present  = 1'b1;
          res_new.position = torq_pkg::POS_W'(rank);
          n_rm             = CW'(rank) + CW'(1);
        end
      end
      default: begin
        res_new = '0;
      end
    endcase
    occ_new           = do_add ? (occ + CW'(1)) : (occ - n_rm);
    res_new.removed   = torq_pkg::CNT_W'(n_rm);
    res_new.occupancy = torq_pkg::CNT_W'(occ_new);
  end

  // Chain commands
  always_comb begin
    ctl.cap    = accept;
    ctl.add_go = (state == S_DEC) && do_add;
    ctl.shl    = (state == S_SHIFT) && (sh_cnt != '0);
  end

  // Request, result and output data registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req <= in_data;
    end
    if (state == S_DEC) begin
      res <= res_new;
    end
    if (out_load) begin
      out_data <= (state == S_DEC) ? res_new : res;
    end
  end

  // Sequencer, occupancy and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occ       <= '0;
      sh_cnt    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_DEC;
          end
        end
        S_DEC: begin
          occ    <= occ_new;
          sh_cnt <= n_rm;
          state  <= out_load ? S_IDLE : S_SHIFT;
        end
        S_SHIFT: begin
          if (sh_cnt != '0) begin
            sh_cnt <= sh_cnt - CW'(1);
          end else if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  // Occupancy never passes the table depth
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= CW'(TABLE_DEPTH))
    else $error("occupancy beyond table depth");

  // Ids stay unique, so at most one cell matches
  a_match_unique: assert property (@(posedge clk) disable iff (rst)
    (state == S_DEC) |-> $onehot0(match_q))
    else $error("requester id held by more than one cell");

  // The table stays sorted: at most one insertion point
  a_ins_unique: assert property (@(posedge clk) disable iff (rst)
    (state == S_DEC) |-> $onehot0(ins))
    else $error("insertion point not unique");

  // A new result appears only when a request finishes its work
  a_out_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_DEC || $past(state) == S_SHIFT))
    else $error("result without a request in work");

  // An overflowing add reports a full table
  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.overflow) |->
      (out_data.occupancy == torq_pkg::CNT_W'(TABLE_DEPTH)))
    else $error("overflow reported on a table that is not full");
`endif

endmodule

### rtl/torq_cell.sv
// One slot of the sorted request chain: holds an id and stamp, compares
// them with a new request, and moves data to or from its neighbors.
// Depends on torq_pkg.
module torq_cell (
  input  logic                             clk,
  input  torq_pkg::cell_ctl_t              ctl,
  input  logic                             occupied,
  input  logic [torq_pkg::ID_W-1:0]        cmp_id,
  input  logic [torq_pkg::STAMP_W-1:0]     cmp_stamp,
  input  logic [torq_pkg::ID_W-1:0]        new_id,
  input  logic [torq_pkg::STAMP_W-1:0]     new_stamp,
  input  logic                             left_before,
  input  logic [torq_pkg::ID_W-1:0]        left_id,
  input  logic [torq_pkg::STAMP_W-1:0]     left_stamp,
  input  logic [torq_pkg::ID_W-1:0]        right_id,
  input  logic [torq_pkg::STAMP_W-1:0]     right_stamp,
  output logic [torq_pkg::ID_W-1:0]        id,
  output logic [torq_pkg::STAMP_W-1:0]     stamp,
  output logic                             match,
  output logic                             new_first
);

  logic hit;
  logic goes_first;

  // Compare against the request: same id, and does the request sort first
  assign hit        = occupied && (cmp_id == id);
  assign goes_first = !occupied || (cmp_stamp < stamp) ||
                      ((cmp_stamp == stamp) && (cmp_id < id));

  always_ff @(posedge clk) begin
    if (ctl.cap) begin
      match     <= hit;
      new_first <= goes_first;
    end
  end

  // Data movement: insert shifts toward the tail, removal toward the head
  always_ff @(posedge clk) begin
    if (ctl.add_go) begin
      if (left_before) begin
        id    <= left_id;
        stamp <= left_stamp;
      end else if (new_first) begin
        id    <= new_id;
        stamp <= new_stamp;
      end
    end else if (ctl.shl) begin
      id    <= right_id;
      stamp <= right_stamp;
    end
  end

endmodule

### rtl/torq_enc.sv
// One-hot to binary index encoder for the cell flag vectors.
// No dependencies.
module torq_enc #(
  parameter int unsigned N = 16,
  parameter int unsigned W = 4
) (
  input  logic [N-1:0] onehot,
  output logic [W-1:0] index
);

  // OR together the index of every set bit; at most one is set
  always_comb begin
    index = '0;
    for (int k = 0; k < N; k++) begin
      if (onehot[k]) begin
        index = index | W'(k);
      end
    end
  end

endmodule

### verif/testbench.sv
// Self-checking testbench for timestamp_ordered_request_table: directed table, then random requests.
// Holds its own predictor of the sorted request table and compares every result field.
// Depends on torq_pkg and the RTL of timestamp_ordered_request_table.
`timescale 1ns / 100ps

module testbench;

  localparam int DEPTH        = 16;
  localparam int RAND_ITEMS   = 1750;
  localparam int BLOCK_ITEMS  = 250;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 400000;

  localparam int ID_W    = torq_pkg::ID_W;
  localparam int STAMP_W = torq_pkg::STAMP_W;
  localparam int CNT_W   = torq_pkg::CNT_W;
  localparam int POS_W   = torq_pkg::POS_W;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  torq_pkg::req_t in_data;
  logic out_valid;
  logic out_stall;
  torq_pkg::rsp_t out_data;

  // Directed row: request plus an optional hand-written expectation
  typedef struct {
    torq_pkg::req_t req;
    bit             typed;
    torq_pkg::rsp_t exp;
  } dir_row_t;

  // Predicted table contents, kept sorted like the hardware
  logic [ID_W-1:0]    tbl_ids[DEPTH];
  logic [STAMP_W-1:0] tbl_stamps[DEPTH];
  int                 tbl_fill;

  torq_pkg::rsp_t expected_rsp[$];
  dir_row_t       dir_rows[$];

  int  n_errors;
  int  n_checked;
  int  n_ops[4];
  int  n_refused;
  int  cycles;
  bit  send_idle;
  bit  recv_idle;

  timestamp_ordered_request_table #(.TABLE_DEPTH(DEPTH)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Rank of an id in the predicted table, -1 if absent
  function automatic int find_slot(logic [ID_W-1:0] id);
    for (int k = 0; k < tbl_fill; k++)
      if (tbl_ids[k] == id) return k;
    return -1;
  endfunction

  function automatic void shift_out_front(int n);
    for (int k = n; k < tbl_fill; k++) begin
      tbl_ids[k-n]    = tbl_ids[k];
      tbl_stamps[k-n] = tbl_stamps[k];
    end
    tbl_fill -= n;
  endfunction

  // Apply one request to the predicted table and return its result
  function automatic torq_pkg::rsp_t serve_request(torq_pkg::req_t r);
    torq_pkg::rsp_t res;
    int   rank;
    int   slot;
    int   n;
    res  = '0;
    rank = find_slot(r.requester_id);
    n_ops[r.req_type]++;
    case (r.req_type)
      torq_pkg::OP_ADD: begin
        if (rank >= 0) begin
          res.present  = 1'b1;
          res.position = POS_W'(rank);
        end else if (tbl_fill >= DEPTH) begin
          res.overflow = 1'b1;
          n_refused++;
        end else begin
          // first slot that orders after the new (stamp, id)
          slot = 0;
          while (slot < tbl_fill &&
                 !(r.time_stamp < tbl_stamps[slot] ||
                   (r.time_stamp == tbl_stamps[slot] && r.requester_id < tbl_ids[slot])))
            slot++;
          for (int k = tbl_fill; k > slot; k--) begin
            tbl_ids[k]    = tbl_ids[k-1];
            tbl_stamps[k] = tbl_stamps[k-1];
          end
          tbl_ids[slot]    = r.requester_id;
          tbl_stamps[slot] = r.time_stamp;
          tbl_fill++;
          res.present  = 1'b1;
          res.position = POS_W'(slot);
        end
      end
      torq_pkg::OP_QUERY: begin
        if (rank >= 0) begin
          res.present  = 1'b1;
          res.position = POS_W'(rank);
          res.granted  = (rank < int'(r.count));
        end
      end
      torq_pkg::OP_DROP: begin
        n = (int'(r.count) < tbl_fill) ? int'(r.count) : tbl_fill;
        shift_out_front(n);
        res.removed = CNT_W'(n);
      end
      default: begin
        if (rank >= 0) begin
          res.present  = 1'b1;
          res.position = POS_W'(rank);
          shift_out_front(rank + 1);
          res.removed = CNT_W'(rank + 1);
        end
      end
    endcase
    res.occupancy = CNT_W'(tbl_fill);
    return res;
  endfunction

  function automatic torq_pkg::req_t mk_req(logic [1:0] op, logic [ID_W-1:0] id,
                                            logic [STAMP_W-1:0] stamp,
                                            logic [CNT_W-1:0] cnt);
    torq_pkg::req_t r;
    r.req_type     = op;
    r.requester_id = id;
    r.time_stamp   = stamp;
    r.count        = cnt;
    return r;
  endfunction

  function automatic torq_pkg::rsp_t mk_rsp(bit pres, int pos, bit grant, int rem, int occ,
                                            bit ovf);
    torq_pkg::rsp_t s;
    s.present   = pres;
    s.position  = POS_W'(pos);
    s.granted   = grant;
    s.removed   = CNT_W'(rem);
    s.occupancy = CNT_W'(occ);
    s.overflow  = ovf;
    return s;
  endfunction

  function automatic void add_row(torq_pkg::req_t r, bit typed, torq_pkg::rsp_t exp);
    dir_row_t row;
    row.req   = r;
    row.typed = typed;
    row.exp   = exp;
    dir_rows  = {dir_rows, row};
  endfunction

  function automatic logic [STAMP_W-1:0] rand_stamp();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2, 3:    return STAMP_W'($urandom_range(0, 7));
      default: return w[STAMP_W-1:0];
    endcase
  endfunction

  // Mostly ids from a small pool or ids already queued, so queries and releases hit
  function automatic torq_pkg::req_t rand_request(int add_pct);
    logic [1:0]      op;
    logic [ID_W-1:0] id;
    logic [CNT_W-1:0] cnt;
    int              p;
    p = $urandom_range(0, 99);
    if (p < add_pct) op = torq_pkg::OP_ADD;
    else begin
      case ($urandom_range(0, 3))
        0, 1:    op = torq_pkg::OP_QUERY;
        2:       op = torq_pkg::OP_DROP;
        default: op = torq_pkg::OP_RELEASE;
      endcase
    end
    if ($urandom_range(0, 9) == 0) id = ID_W'($urandom_range(0, 255));
    else id = ID_W'($urandom_range(0, 23));
    if (op != torq_pkg::OP_ADD && tbl_fill > 0 && $urandom_range(0, 9) < 6)
      id = tbl_ids[$urandom_range(0, tbl_fill - 1)];
    if ($urandom_range(0, 9) == 0) cnt = CNT_W'($urandom_range(17, 31));
    else cnt = CNT_W'($urandom_range(0, 16));
    if (op == torq_pkg::OP_DROP && $urandom_range(0, 9) < 7) cnt = CNT_W'($urandom_range(0, 3));
    return mk_req(op, id, rand_stamp(), cnt);
  endfunction

  // Present one request, wait for its accept, then record the expected result
  task automatic send_request(torq_pkg::req_t r, bit typed, torq_pkg::rsp_t exp);
    int   gap;
    torq_pkg::rsp_t predicted;
    gap = send_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall);
    predicted = serve_request(r);
    expected_rsp = {expected_rsp, (typed ? exp : predicted)};
    @(negedge clk);
  endtask

  // Result side: random stall before each accepted result
  initial begin : result_side
    int w;
    @(negedge clk);
    forever begin
      w = recv_idle ? $urandom_range(0, 9) : 0;
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Compare every accepted result against the oldest expectation
  always @(posedge clk) begin : result_check
    torq_pkg::rsp_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_rsp.size() == 0) begin
        $error("unexpected result %h with nothing outstanding", out_data);
        n_errors++;
      end else begin
        e = expected_rsp.pop_front();
        n_checked++;
        if (out_data.present !== e.present) begin
          $error("present: expected %0d, got %0d", e.present, out_data.present);
          n_errors++;
        end
        if (out_data.position !== e.position) begin
          $error("position: expected %0d, got %0d", e.position, out_data.position);
          n_errors++;
        end
        if (out_data.granted !== e.granted) begin
          $error("granted: expected %0d, got %0d", e.granted, out_data.granted);
          n_errors++;
        end
        if (out_data.removed !== e.removed) begin
          $error("removed: expected %0d, got %0d", e.removed, out_data.removed);
          n_errors++;
        end
        if (out_data.occupancy !== e.occupancy) begin
          $error("occupancy: expected %0d, got %0d", e.occupancy, out_data.occupancy);
          n_errors++;
        end
        if (out_data.overflow !== e.overflow) begin
          $error("overflow: expected %0d, got %0d", e.overflow, out_data.overflow);
          n_errors++;
        end
      end
    end
  end

  initial begin : main_flow
    int   add_pct;
    torq_pkg::rsp_t none;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    n_errors  = 0;
    n_checked = 0;
    n_refused = 0;
    cycles    = 0;
    tbl_fill  = 0;
    n_ops     = '{default: 0};
    send_idle = 1'b1;
    recv_idle = 1'b1;
    none      = '0;

    // Empty table, then ties on stamp zero, duplicate add and grant boundary
    add_row(mk_req(torq_pkg::OP_QUERY, 8'd5, '0, 5'd16), 1, mk_rsp(0, 0, 0, 0, 0, 0));
    add_row(mk_req(torq_pkg::OP_DROP, 8'd0, '1, 5'd31), 1, mk_rsp(0, 0, 0, 0, 0, 0));
    add_row(mk_req(torq_pkg::OP_ADD, 8'hFF, '1, 5'd0), 1, mk_rsp(1, 0, 0, 0, 1, 0));
    add_row(mk_req(torq_pkg::OP_ADD, 8'h00, '0, 5'd31), 1, mk_rsp(1, 0, 0, 0, 2, 0));
    add_row(mk_req(torq_pkg::OP_ADD, 8'h01, '0, 5'd0), 1, mk_rsp(1, 1, 0, 0, 3, 0));
    add_row(mk_req(torq_pkg::OP_ADD, 8'h00, 48'd5, 5'd0), 1, mk_rsp(1, 0, 0, 0, 3, 0));
    add_row(mk_req(torq_pkg::OP_QUERY, 8'hFF, '0, 5'd0), 1, mk_rsp(1, 2, 0, 0, 3, 0));
    add_row(mk_req(torq_pkg::OP_QUERY, 8'h01, '0, 5'd1), 0, none);
    add_row(mk_req(torq_pkg::OP_QUERY, 8'h01, '0, 5'd2), 0, none);
    add_row(mk_req(torq_pkg::OP_RELEASE, 8'h00, '0, 5'd0), 1, mk_rsp(1, 0, 0, 1, 2, 0));
    add_row(mk_req(torq_pkg::OP_RELEASE, 8'h07, '1, 5'd31), 1, mk_rsp(0, 0, 0, 0, 2, 0));
    // Fill to capacity with repeating stamps so ids break the ties
    for (int k = 0; k < DEPTH - 2; k++)
      add_row(mk_req(torq_pkg::OP_ADD, ID_W'(8'h10 + k), STAMP_W'((k % 3) * 1000), 5'd0),
              0, none);
    // Full table refuses a new id; releasing the last entry empties it
    add_row(mk_req(torq_pkg::OP_ADD, 8'h80, 48'd1, 5'd0), 1, mk_rsp(0, 0, 0, 0, 16, 1));
    add_row(mk_req(torq_pkg::OP_RELEASE, 8'hFF, '0, 5'd0), 1, mk_rsp(1, 15, 0, 16, 0, 0));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i])
      send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].exp);

    // Random blocks: the first fills hard with idling, the second runs flat out, the rest are random
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % BLOCK_ITEMS == 0) begin
        case (i / BLOCK_ITEMS)
          0: begin
            add_pct   = 80;
            send_idle = 1'b1;
            recv_idle = 1'b1;
          end
          1: begin
            add_pct   = 50;
            send_idle = 1'b0;
            recv_idle = 1'b0;
          end
          default: begin
            add_pct   = $urandom_range(20, 85);
            send_idle = ($urandom_range(0, 2) != 0);
            recv_idle = ($urandom_range(0, 2) != 0);
          end
        endcase
      end
      send_request(rand_request(add_pct), 0, none);
    end
    in_valid <= 1'b0;

    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests: %0d add, %0d query, %0d drop, %0d release.",
             n_ops[torq_pkg::OP_ADD] + n_ops[torq_pkg::OP_QUERY] +
             n_ops[torq_pkg::OP_DROP] + n_ops[torq_pkg::OP_RELEASE],
             n_ops[torq_pkg::OP_ADD], n_ops[torq_pkg::OP_QUERY],
             n_ops[torq_pkg::OP_DROP], n_ops[torq_pkg::OP_RELEASE]);
    $display("Checked %0d results; %0d adds were refused on a full table.",
             n_checked, n_refused);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
